@@ src/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// Store geometry, operation codes, status codes and stream widths.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int DEPTH   = 1024;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = 11;
	localparam int WORD_W  = 64;
	localparam int OP_W    = 3;
	localparam int ST_W    = 2;

	localparam int S_DATA_W = 80;
	localparam int M_DATA_W = 96;

	localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
	localparam logic [OP_W-1:0] OP_LOCATE   = 3'd2;
	localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;
	localparam logic [OP_W-1:0] OP_NEXT     = 3'd5;
	localparam logic [OP_W-1:0] OP_PREV     = 3'd6;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_NOPOS = 2'd2;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;

endpackage

@@ src/ple_store.sv @@
// ----------------------------------------------------------------------------
// ple_store: entry store of the positional list engine
// Single-clock memory with one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module ple_store (
	input  logic           clk,
	input  logic           we,
	input  ple_pkg::addr_t waddr,
	input  ple_pkg::word_t wdata,
	input  ple_pkg::addr_t raddr,
	output ple_pkg::word_t rdata
);

	ple_pkg::word_t mem [ple_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ src/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of 64-bit words with 1-based positions
// Insert, delete, locate, retrieve, clear, next and prev on a list kept in a
// single store; one result transfer for every operation transfer.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_*      in         tuser: operation; tdata: position, word
//  m_*      out        tdata: status, result_position, result_word, count,
//                      is_empty
//
// Clear, next, prev, rejected operations and a delete of the last entry go
// straight to the result; retrieve reads one entry. An insert first moves the
// entries from its position on up by one, if any, then writes the word; delete
// moves the entries behind it down by one; locate walks from the first entry
// to a match or the end. The store gives one read and one write per cycle.
// Reset empties the list at once. Only one operation is in work at a time; a
// finished result waits in the output register until it is taken.
// ----------------------------------------------------------------------------
module positional_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,   // operation
	input  logic [79:0] s_tdata,   // position[10:0], word[74:11], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // status[1:0], result_position[12:2],
	                               // result_word[76:13], count[87:77],
	                               // is_empty[88], zero fill
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SHIFT = 3'd1;
	localparam logic [2:0] S_PUT   = 3'd2;
	localparam logic [2:0] S_LOC   = 3'd3;
	localparam logic [2:0] S_RET   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	localparam int CW = ple_pkg::CNT_W;

	logic [2:0]                  state_q;
	logic [CW-1:0]               cnt_q;
	logic                        rd_act_q;
	logic                        wr_pend_q;
	logic                        m_tvalid_q;
	ple_pkg::addr_t              rd_ptr_q;
	ple_pkg::addr_t              stop_q;
	ple_pkg::addr_t              lst_q;
	logic                        up_q;
	logic [ple_pkg::OP_W-1:0]    op_q;
	logic [CW-1:0]               pos_q;
	ple_pkg::word_t              word_q;
	logic [ple_pkg::ST_W-1:0]    st_q;
	logic [CW-1:0]               rpos_q;
	ple_pkg::word_t              rword_q;
	logic [ple_pkg::M_DATA_W-1:0] m_tdata_q;

	logic                        accept;
	logic [ple_pkg::OP_W-1:0]    in_op;
	logic [CW-1:0]               in_pos;
	ple_pkg::word_t              in_word;
	logic [CW-1:0]               cnt_inc;
	logic                        out_load;
	logic                        loc_hit;
	logic                        walk_done;

	logic                        mem_we;
	ple_pkg::addr_t              mem_waddr;
	ple_pkg::word_t              mem_wdata;
	ple_pkg::word_t              mem_rdata;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign in_op     = s_tuser;
	assign in_pos    = s_tdata[CW-1:0];
	assign in_word   = s_tdata[CW+ple_pkg::WORD_W-1:CW];
	assign cnt_inc   = cnt_q + CW'(1);
	assign out_load  = (state_q == S_FIN) && (!m_tvalid_q || m_tready);
	assign loc_hit   = wr_pend_q && (mem_rdata == word_q);
	assign walk_done = !rd_act_q && !wr_pend_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = up_q ? (lst_q - ple_pkg::ADDR_W'(1)) : (lst_q + ple_pkg::ADDR_W'(1));
		mem_wdata = mem_rdata;
		if (state_q == S_SHIFT) begin
			mem_we = wr_pend_q;
		end else if (state_q == S_PUT) begin
			mem_we    = 1'b1;
			mem_waddr = ple_pkg::ADDR_W'(pos_q - CW'(1));
			mem_wdata = word_q;
		end
	end

	ple_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_ptr_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			rd_act_q   <= 1'b0;
			wr_pend_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			wr_pend_q <= rd_act_q;
			if (rd_act_q && (rd_ptr_q == stop_q)) begin
				rd_act_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FIN;
						unique case (in_op)
							ple_pkg::OP_INSERT: begin
								if (cnt_q >= CW'(ple_pkg::DEPTH)) begin
									state_q <= S_FIN;
								end else if (in_pos == '0 || in_pos > cnt_inc) begin
									state_q <= S_FIN;
								end else if (in_pos <= cnt_q) begin
									rd_act_q <= 1'b1;
									state_q  <= S_SHIFT;
								end else begin
									state_q <= S_PUT;
								end
							end
							ple_pkg::OP_DELETE: begin
								if (in_pos == '0 || in_pos > cnt_q) begin
									state_q <= S_FIN;
								end else if (in_pos < cnt_q) begin
									rd_act_q <= 1'b1;
									state_q  <= S_SHIFT;
								end else begin
									cnt_q <= cnt_q - CW'(1);
								end
							end
							ple_pkg::OP_LOCATE: begin
								if (cnt_q != '0) begin
									rd_act_q <= 1'b1;
									state_q  <= S_LOC;
								end
							end
							ple_pkg::OP_RETRIEVE: begin
								if (in_pos != '0 && in_pos <= cnt_q) begin
									rd_act_q <= 1'b1;
									state_q  <= S_RET;
								end
							end
							ple_pkg::OP_CLEAR: begin
								cnt_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (walk_done) begin
						if (op_q == ple_pkg::OP_INSERT) begin
							state_q <= S_PUT;
						end else begin
							cnt_q   <= cnt_q - CW'(1);
							state_q <= S_FIN;
						end
					end
				end
				S_PUT: begin
					cnt_q   <= cnt_inc;
					state_q <= S_FIN;
				end
				S_LOC: begin
					if (loc_hit) begin
						rd_act_q <= 1'b0;
						state_q  <= S_FIN;
					end else if (walk_done) begin
						state_q <= S_FIN;
					end
				end
				S_RET: begin
					if (wr_pend_q) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_act_q) begin
			lst_q <= rd_ptr_q;
			if (rd_ptr_q != stop_q) begin
				rd_ptr_q <= up_q ? (rd_ptr_q + ple_pkg::ADDR_W'(1))
				                 : (rd_ptr_q - ple_pkg::ADDR_W'(1));
			end
		end

		if (out_load) begin
			m_tdata_q <= {7'd0, (cnt_q == '0), cnt_q, rword_q, rpos_q, st_q};
		end

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q    <= in_op;
					pos_q   <= in_pos;
					word_q  <= in_word;
					st_q    <= ple_pkg::ST_OK;
					rpos_q  <= '0;
					rword_q <= '0;
					unique case (in_op)
						ple_pkg::OP_INSERT: begin
							rd_ptr_q <= ple_pkg::ADDR_W'(cnt_q - CW'(1));
							stop_q   <= ple_pkg::ADDR_W'(in_pos - CW'(1));
							up_q     <= 1'b0;
							if (cnt_q >= CW'(ple_pkg::DEPTH)) begin
								st_q <= ple_pkg::ST_FULL;
							end else if (in_pos == '0 || in_pos > cnt_inc) begin
								st_q <= ple_pkg::ST_NOPOS;
							end
						end
						ple_pkg::OP_DELETE: begin
							rd_ptr_q <= ple_pkg::ADDR_W'(in_pos);
							stop_q   <= ple_pkg::ADDR_W'(cnt_q - CW'(1));
							up_q     <= 1'b1;
							if (in_pos == '0 || in_pos > cnt_q) begin
								st_q <= ple_pkg::ST_NOPOS;
							end
						end
						ple_pkg::OP_LOCATE: begin
							rd_ptr_q <= '0;
							stop_q   <= ple_pkg::ADDR_W'(cnt_q - CW'(1));
							up_q     <= 1'b1;
							rpos_q   <= cnt_inc;
						end
						ple_pkg::OP_RETRIEVE: begin
							rd_ptr_q <= ple_pkg::ADDR_W'(in_pos - CW'(1));
							stop_q   <= ple_pkg::ADDR_W'(in_pos - CW'(1));
							up_q     <= 1'b1;
							if (in_pos == '0 || in_pos > cnt_q) begin
								st_q <= ple_pkg::ST_NOPOS;
							end
						end
						ple_pkg::OP_NEXT: begin
							if (in_pos != '0 && in_pos <= cnt_q) begin
								rpos_q <= in_pos + CW'(1);
							end
						end
						ple_pkg::OP_PREV: begin
							if (in_pos > CW'(1) && in_pos <= cnt_inc) begin
								rpos_q <= in_pos - CW'(1);
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_LOC: begin
				if (loc_hit) begin
					rpos_q <= CW'(lst_q) + CW'(1);
				end
			end
			S_RET: begin
				if (wr_pend_q) begin
					rword_q <= mem_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
